[hdl/mrrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, constants and the CRC16 byte update for the Modbus RTU
// response checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 11;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int SPAN_W      = 9;          // 3 + 255 fits in 9 bits
    localparam int MAX_LEN     = FRAME_BYTES - 5;

    // Header byte positions and the data bytes that carry the values
    localparam logic [POS_W-1:0] POS_ADDR  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_FUNC  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DATA0 = POS_W'(3);
    localparam logic [POS_W-1:0] POS_DATAN = POS_W'(8);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END   = POS_W'(FRAME_BYTES);

    // Modbus constants
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
    localparam logic [7:0]  ADDR_RESET     = 8'h01;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_HDR_ERR = 2'd1,
        STATUS_CRC_ERR = 2'd2,
        STATUS_LEN_ERR = 2'd3
    } status_t;

    // One finished frame report
    typedef struct packed {
        logic        last;
        status_t     status;
        logic [15:0] nitrogen;
        logic [15:0] phosphorus;
        logic [15:0] potassium;
    } frame_res_t;

    // Reflected CRC16 update over one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[hdl/mrrc_frame_track.sv]
// ----------------------------------------------------------------------------
// mrrc_frame_track
// Per-frame state: byte position, header check, length, running CRC,
// CRC snapshot, received CRC and value bytes. Reports on the last byte.
// ----------------------------------------------------------------------------
module mrrc_frame_track (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    input  logic                   frame_start,
    input  logic [7:0]             device_address,
    output mrrc_pkg::frame_res_t   res
);
    import mrrc_pkg::*;

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [15:0]       crc_reg,  crc_next;
    logic [15:0]       comp_reg, comp_next;
    logic [15:0]       rcv_reg,  rcv_next;
    logic [7:0]        len_reg,  len_next;
    logic              hdr_reg,  hdr_next;
    logic [47:0]       val_reg,  val_next;

    logic [POS_W-1:0]  pos;
    logic [15:0]       crc_base, comp_base, rcv_base;
    logic [7:0]        len_base;
    logic              hdr_base;
    logic [47:0]       val_base;
    logic              active;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] pos_wide;
    logic [2:0]        val_idx;
    status_t           status;

    // Frame start restarts from the reset state
    always_comb begin
        pos       = frame_start ? '0 : pos_reg;
        crc_base  = frame_start ? CRC_INIT : crc_reg;
        comp_base = frame_start ? '0 : comp_reg;
        rcv_base  = frame_start ? '0 : rcv_reg;
        len_base  = frame_start ? '0 : len_reg;
        hdr_base  = frame_start ? 1'b0 : hdr_reg;
        val_base  = frame_start ? '0 : val_reg;
    end

    // Next frame state for this byte
    always_comb begin
        active    = (pos < POS_END);
        pos_wide  = SPAN_W'(pos);
        pos_next  = pos;
        hdr_next  = hdr_base;
        len_next  = len_base;
        crc_next  = crc_base;
        comp_next = comp_base;
        rcv_next  = rcv_base;
        val_next  = val_base;
        val_idx   = 3'(POS_DATAN - pos);
        span      = SPAN_W'(3);
        if (active) begin
            pos_next = pos + POS_W'(1);
            if (pos == POS_ADDR) begin
                hdr_next = (rx_byte == device_address);
            end else if (pos == POS_FUNC) begin
                hdr_next = hdr_base && (rx_byte == FUNC_READ_HOLD);
            end else if (pos == POS_LEN) begin
                len_next = rx_byte;
            end
            // CRC covers address, function, length and L data bytes
            if (pos >= POS_DATA0) begin
                span = SPAN_W'(3) + SPAN_W'(len_next);
            end
            if (pos_wide < span) begin
                crc_next = crc16_byte(crc_base, rx_byte);
            end
            // Snapshot CRC and capture the little-endian received CRC
            if (pos >= POS_DATA0) begin
                if (pos_wide == span) begin
                    comp_next = crc_base;
                    rcv_next  = {rcv_base[15:8], rx_byte};
                end else if (pos_wide == span + SPAN_W'(1)) begin
                    rcv_next  = {rx_byte, rcv_base[7:0]};
                end
            end
            // Value bytes, first data byte in the top octet
            if (pos >= POS_DATA0 && pos <= POS_DATAN) begin
                val_next[{val_idx, 3'b000} +: 8] = rx_byte;
            end
        end
    end

    // Status, header first, then length, then CRC
    always_comb begin
        priority if (!hdr_next) begin
            status = STATUS_HDR_ERR;
        end else if (len_next > 8'(MAX_LEN)) begin
            status = STATUS_LEN_ERR;
        end else if (comp_next != rcv_next) begin
            status = STATUS_CRC_ERR;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        res.last       = active && (pos == POS_LAST);
        res.status     = status;
        res.nitrogen   = (status == STATUS_OK) ? val_next[47:32] : '0;
        res.phosphorus = (status == STATUS_OK) ? val_next[31:16] : '0;
        res.potassium  = (status == STATUS_OK) ? val_next[15:0]  : '0;
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            crc_reg  <= CRC_INIT;
            comp_reg <= '0;
            rcv_reg  <= '0;
            len_reg  <= '0;
            hdr_reg  <= 1'b0;
            val_reg  <= '0;
        end else if (step) begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            comp_reg <= comp_next;
            rcv_reg  <= rcv_next;
            len_reg  <= len_next;
            hdr_reg  <= hdr_next;
            val_reg  <= val_next;
        end
    end

endmodule

[hdl/modbus_rtu_response_checker.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks Modbus RTU read-holding-registers responses with three values.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction, up to one per clock, and reports
// one result on the last byte of each fixed-length frame: status (ok, header
// mismatch, CRC mismatch, length too large) and three big-endian 16-bit
// values, zero unless the status is ok. A byte passes an input register and
// is folded into the frame state through a one-byte CRC16 update; the report
// is loaded into the output register as the last byte is folded. While a
// report waits for m_ready, the byte in the input register waits behind it.
// s_frame_start marks byte 0 and drops any partial frame; bytes past the
// frame end are ignored until the next frame start. The expected slave
// address must be written through cfg_wr_en/cfg_wr_data only while idle,
// by the user; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // received bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_start,
    // frame reports
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_valid_res,
    output logic [15:0] m_nitrogen,
    output logic [15:0] m_phosphorus,
    output logic [15:0] m_potassium
);
    import mrrc_pkg::*;

    logic [7:0]  addr_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [15:0] out_n_reg, out_p_reg, out_k_reg;

    logic        can_load;
    logic        advance;
    frame_res_t  res;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= ADDR_RESET;
        end else if (cfg_wr_en) begin
            addr_reg <= cfg_wr_data;
        end
    end

    // Handshake flow
    assign can_load = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && can_load;
    assign s_ready  = !in_valid_reg || can_load;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_rx_byte;
            in_start_reg <= s_frame_start;
        end
    end

    mrrc_frame_track u_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .rx_byte        (in_byte_reg),
        .frame_start    (in_start_reg),
        .device_address (addr_reg),
        .res            (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (can_load) begin
            out_valid_reg <= advance && res.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.last && can_load) begin
            out_status_reg <= res.status;
            out_n_reg      <= res.nitrogen;
            out_p_reg      <= res.phosphorus;
            out_k_reg      <= res.potassium;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_valid_res  = (out_status_reg == STATUS_OK);
    assign m_nitrogen   = out_n_reg;
    assign m_phosphorus = out_p_reg;
    assign m_potassium  = out_k_reg;

endmodule

[tb/modbus_rtu_response_checker_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response checker scoreboard
// Tracks the Modbus RTU frame state from the accepted bytes and checks each
// frame report. Also holds the CRC16 fold that the stimulus uses to build
// well-formed frames.
// ----------------------------------------------------------------------------
package mrrc_tb_pkg;

    import mrrc_pkg::*;

    // Modbus CRC16, reflected, one byte folded in LSB first
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] acc;
        logic        lsb;
        acc = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            lsb = acc[0];
            acc = {1'b0, acc[15:1]};
            if (lsb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

endpackage

module mrrc_frame_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  logic             s_frame_start,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [1:0]       m_status,
    input  logic             m_valid_res,
    input  logic [15:0]      m_nitrogen,
    input  logic [15:0]      m_phosphorus,
    input  logic [15:0]      m_potassium,
    output int               mismatch_count,
    output int               reports_pending,
    output logic [3:0][15:0] status_tally
);

    import mrrc_pkg::*;
    import mrrc_tb_pkg::*;

    typedef struct {
        status_t     status;
        logic        valid_res;
        logic [15:0] nitrogen;
        logic [15:0] phosphorus;
        logic [15:0] potassium;
    } frame_report_t;

    frame_report_t expected_reports [$];

    // Shadow of the slave address register
    logic [7:0]  slave_addr;

    // Frame tracking state
    int          frame_pos;
    logic [15:0] crc_run;
    logic [15:0] crc_snap;
    logic [15:0] crc_rx;
    logic [7:0]  len_byte;
    logic        hdr_match;
    logic [47:0] value_bytes;

    int               err_acc = 0;
    logic [3:0][15:0] tally_acc = '0;

    task automatic restart_frame();
        frame_pos   = 0;
        crc_run     = CRC_INIT;
        crc_snap    = '0;
        crc_rx      = '0;
        len_byte    = '0;
        hdr_match   = 1'b0;
        value_bytes = '0;
    endtask

    // Fold one accepted byte into the frame; queue a report on the last byte
    task automatic fold_byte(input logic [7:0] b, input logic first);
        int            p;
        int            span;
        frame_report_t rep;
        if (first) begin
            restart_frame();
        end
        p = frame_pos;
        // past the frame end: ignored until the next start flag
        if (p >= FRAME_BYTES) begin
            return;
        end
        case (p)
            POS_ADDR: begin
                hdr_match = (b == slave_addr);
            end
            POS_FUNC: begin
                hdr_match = hdr_match && (b == FUNC_READ_HOLD);
            end
            POS_LEN: begin
                len_byte = b;
            end
            default: ;
        endcase
        // CRC covers the header plus the length byte's count of data bytes
        span = POS_DATA0 + ((p < POS_DATA0) ? 0 : int'(len_byte));
        if (p < span) begin
            crc_run = crc16_fold(crc_run, b);
        end
        if (p >= POS_DATA0 && p == span) begin
            crc_snap    = crc_run;
            crc_rx[7:0] = b;
        end else if (p >= POS_DATA0 && p == span + 1) begin
            crc_rx[15:8] = b;
        end
        if (p >= POS_DATA0 && p <= POS_DATAN) begin
            value_bytes[(POS_DATAN - p) * 8 +: 8] = b;
        end
        frame_pos = p + 1;
        if (p != POS_LAST) begin
            return;
        end
        // header first, then length, then CRC
        if (!hdr_match) begin
            rep.status = STATUS_HDR_ERR;
        end else if (len_byte > MAX_LEN) begin
            rep.status = STATUS_LEN_ERR;
        end else if (crc_snap != crc_rx) begin
            rep.status = STATUS_CRC_ERR;
        end else begin
            rep.status = STATUS_OK;
        end
        rep.valid_res = (rep.status == STATUS_OK);
        {rep.nitrogen, rep.phosphorus, rep.potassium} = rep.valid_res ? value_bytes : 48'h0;
        expected_reports.push_back(rep);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_acc++;
        end
    endtask

    task automatic compare_report();
        frame_report_t rep;
        if (expected_reports.size() == 0) begin
            $error("unexpected frame report: status %0d", m_status);
            err_acc++;
            return;
        end
        rep = expected_reports.pop_front();
        tally_acc[rep.status] = tally_acc[rep.status] + 16'd1;
        check_field("status",     16'(rep.status),    16'(m_status));
        check_field("valid_res",  16'(rep.valid_res), 16'(m_valid_res));
        check_field("nitrogen",   rep.nitrogen,       m_nitrogen);
        check_field("phosphorus", rep.phosphorus,     m_phosphorus);
        check_field("potassium",  rep.potassium,      m_potassium);
    endtask

    // Track each transaction on both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr = ADDR_RESET;
            restart_frame();
            expected_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                slave_addr = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                fold_byte(s_rx_byte, s_frame_start);
            end
            if (m_valid && m_ready) begin
                compare_report();
            end
        end
        mismatch_count  <= err_acc;
        reports_pending <= expected_reports.size();
        status_tally    <= tally_acc;
    end

endmodule

[tb/modbus_rtu_response_checker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response checker testbench
// Feeds byte streams of response frames (good, bad header, bad length, bad
// CRC, abandoned, trailing junk and noise) under several slave addresses,
// with random stalls on both channels; the frame checker scores the reports.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_tb;

    import mrrc_pkg::*;
    import mrrc_tb_pkg::*;

    localparam int RANDOM_BYTES   = 1050;
    localparam int PHASES         = 5;
    localparam int STALL_PCT      = 22;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        s_frame_start;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic        m_valid_res;
    logic [15:0] m_nitrogen;
    logic [15:0] m_phosphorus;
    logic [15:0] m_potassium;

    int               mismatch_count;
    int               reports_pending;
    logic [3:0][15:0] status_tally;

    bit         no_idle   = 1'b0;
    bit         hold_req  = 1'b0;
    bit         hold_done = 1'b0;
    logic [7:0] target_addr;
    logic [7:0] frame_buf [FRAME_BYTES];
    int         bytes_sent  = 0;
    int         cfg_writes  = 0;
    int         idle_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    modbus_rtu_response_checker u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_valid_res   (m_valid_res),
        .m_nitrogen    (m_nitrogen),
        .m_phosphorus  (m_phosphorus),
        .m_potassium   (m_potassium)
    );

    mrrc_frame_checker u_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_valid_res     (m_valid_res),
        .m_nitrogen      (m_nitrogen),
        .m_phosphorus    (m_phosphorus),
        .m_potassium     (m_potassium),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending),
        .status_tally    (status_tally)
    );

    // Watchdog: too long without any transaction ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles < WATCHDOG_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Report sink: random back-pressure, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= STALL_PCT);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        while (!no_idle && $urandom_range(0, 99) < STALL_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_rx_byte     <= b;
        s_frame_start <= first;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    task automatic send_frame(input int n, input logic flag);
        for (int i = 0; i < n; i++) begin
            send_byte(frame_buf[i], (i == 0) ? flag : 1'b0);
        end
    endtask

    // Fill frame_buf; a length that fits gets a CRC, optionally corrupted
    task automatic build_frame(input logic [7:0] addr, input logic [7:0] func,
                               input logic [7:0] len, input bit bad_crc);
        logic [15:0] crc;
        int          at;
        crc = CRC_INIT;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            case ($urandom_range(0, 9))
                0:       frame_buf[i] = 8'h00;
                1:       frame_buf[i] = 8'hFF;
                default: frame_buf[i] = 8'($urandom);
            endcase
        end
        frame_buf[POS_ADDR] = addr;
        frame_buf[POS_FUNC] = func;
        frame_buf[POS_LEN]  = len;
        if (len <= MAX_LEN) begin
            for (int i = 0; i < POS_DATA0 + len; i++) begin
                crc = crc16_fold(crc, frame_buf[i]);
            end
            frame_buf[POS_DATA0 + len]     = crc[7:0];
            frame_buf[POS_DATA0 + len + 1] = crc[15:8];
            if (bad_crc) begin
                at = POS_DATA0 + len + $urandom_range(0, 1);
                frame_buf[at] = frame_buf[at] ^ 8'(1 << $urandom_range(0, 7));
            end
        end
    endtask

    // Mostly the full three-value length, sometimes shorter
    function automatic logic [7:0] pick_len();
        return ($urandom_range(0, 9) < 7) ? 8'(MAX_LEN) : 8'($urandom_range(0, MAX_LEN));
    endfunction

    // Stop sending and wait until every report is back and the pipe is quiet
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_pending != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_addr(input logic [7:0] addr);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        target_addr = addr;
        cfg_writes++;
    endtask

    initial begin
        int         counted;
        int         kind;
        int         n;
        bit         held;
        logic [7:0] len;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 8'h00;
        s_valid       <= 1'b0;
        s_rx_byte     <= 8'h00;
        s_frame_start <= 1'b0;
        target_addr = ADDR_RESET;
        held = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first frame after reset carries no start flag
        build_frame(ADDR_RESET, FUNC_READ_HOLD, 8'(MAX_LEN), 1'b0);
        send_frame(FRAME_BYTES, 1'b0);
        // bytes past the frame end are dropped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // partial frame abandoned by the next start flag
        build_frame(ADDR_RESET, FUNC_READ_HOLD, 8'(MAX_LEN), 1'b0);
        send_frame(3, 1'b1);
        // largest length byte
        build_frame(ADDR_RESET, FUNC_READ_HOLD, 8'hFF, 1'b0);
        send_frame(FRAME_BYTES, 1'b1);

        // Random phases, one slave address each
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       ;
                1:       write_addr(8'h00);
                2:       write_addr(8'hFF);
                default: write_addr(8'($urandom_range(0, 255)));
            endcase
            no_idle = (ph == 2);
            counted = 0;
            while (counted < RANDOM_BYTES / PHASES) begin
                if (ph == 3 && !held && counted >= 20) begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                kind = $urandom_range(0, 99);
                if (kind < 55) begin
                    build_frame(target_addr, FUNC_READ_HOLD, pick_len(), 1'b0);
                    send_frame(FRAME_BYTES, 1'b1);
                    counted += FRAME_BYTES;
                end else if (kind < 65) begin
                    build_frame(target_addr, FUNC_READ_HOLD, pick_len(), 1'b1);
                    send_frame(FRAME_BYTES, 1'b1);
                    counted += FRAME_BYTES;
                end else if (kind < 72) begin
                    // wrong slave address
                    build_frame(8'(target_addr ^ $urandom_range(1, 255)), FUNC_READ_HOLD,
                                pick_len(), 1'b0);
                    send_frame(FRAME_BYTES, 1'b1);
                    counted += FRAME_BYTES;
                end else if (kind < 77) begin
                    // wrong function code
                    build_frame(target_addr, 8'(FUNC_READ_HOLD ^ $urandom_range(1, 255)),
                                pick_len(), 1'b0);
                    send_frame(FRAME_BYTES, 1'b1);
                    counted += FRAME_BYTES;
                end else if (kind < 83) begin
                    // length with no room for the CRC
                    len = ($urandom_range(0, 2) == 0) ? 8'(MAX_LEN + 1)
                                                      : 8'($urandom_range(MAX_LEN + 1, 255));
                    build_frame(target_addr, FUNC_READ_HOLD, len, $urandom_range(0, 1));
                    send_frame(FRAME_BYTES, 1'b1);
                    counted += FRAME_BYTES;
                end else if (kind < 89) begin
                    // cut short, dropped by the next start
                    build_frame(target_addr, FUNC_READ_HOLD, pick_len(), 1'b0);
                    n = $urandom_range(1, FRAME_BYTES - 1);
                    send_frame(n, 1'b1);
                    counted += n;
                end else if (kind < 94) begin
                    // good frame followed by junk that must be ignored
                    build_frame(target_addr, FUNC_READ_HOLD, pick_len(), 1'b0);
                    send_frame(FRAME_BYTES, 1'b1);
                    counted += FRAME_BYTES;
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) begin
                        send_byte(8'($urandom), 1'b0);
                    end
                end else begin
                    // raw noise with stray start flags
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++) begin
                        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                    end
                    counted += n;
                end
            end
        end
        no_idle = 1'b0;

        drain();
        $display("Sent %0d bytes over %0d address settings (reset value, 0x00, 0xFF, random).",
                 bytes_sent, cfg_writes + 1);
        $display("Reports: %0d ok, %0d header mismatch, %0d CRC mismatch, %0d length error.",
                 status_tally[STATUS_OK], status_tally[STATUS_HDR_ERR],
                 status_tally[STATUS_CRC_ERR], status_tally[STATUS_LEN_ERR]);
        if (mismatch_count == 0 && reports_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
